### rtl/cssv_pkg.sv
`timescale 1ns / 1ps
// types and constants for the current-sensed valve sequencer
package cssv_pkg;

	localparam int CURRENT_W = 16;
	localparam int THRESH_W  = 15;
	localparam int CFG_W     = 24;

	// item kinds carried in the mode field
	localparam logic [2:0] MODE_TICK   = 3'd0;
	localparam logic [2:0] MODE_OPEN   = 3'd1;
	localparam logic [2:0] MODE_CLOSE  = 3'd2;
	localparam logic [2:0] MODE_STOP   = 3'd3;
	localparam logic [2:0] MODE_TOGGLE = 3'd4;

	localparam logic [2:0] ST_UNKNOWN = 3'd0;
	localparam logic [2:0] ST_OPEN    = 3'd1;
	localparam logic [2:0] ST_CLOSED  = 3'd2;
	localparam logic [2:0] ST_OPENING = 3'd3;
	localparam logic [2:0] ST_CLOSING = 3'd4;
	localparam logic [2:0] ST_ERROR   = 3'd5;

	localparam logic [1:0] POS_CLOSED = 2'd0;
	localparam logic [1:0] POS_MID    = 2'd1;
	localparam logic [1:0] POS_OPEN   = 2'd2;

	localparam logic [1:0] OP_IDLE    = 2'd0;
	localparam logic [1:0] OP_OPENING = 2'd1;
	localparam logic [1:0] OP_CLOSING = 2'd2;

	localparam logic [3:0] FLT_NONE         = 4'd0;
	localparam logic [3:0] FLT_BOTH_PROBES  = 4'd1;
	localparam logic [3:0] FLT_NO_PROBE     = 4'd2;
	localparam logic [3:0] FLT_OPEN_NOSTART = 4'd3;
	localparam logic [3:0] FLT_CLOSE_NOSTART = 4'd6;
	localparam logic [3:0] FLT_EARLY_OFS    = 4'd1;
	localparam logic [3:0] FLT_TIMEOUT_OFS  = 4'd2;

	localparam logic [1:0] REG_THRESHOLD = 2'd0;
	localparam logic [1:0] REG_TIMEOUT   = 2'd1;
	localparam logic [1:0] REG_INTERVAL  = 2'd2;
	localparam logic [1:0] REG_MIN_RUN   = 2'd3;

	localparam logic [7:0] PROBE_WAIT = 8'd50;
	localparam logic [7:0] NUDGE_WAIT = 8'd100;
	localparam logic [7:0] STAGE_MAX  = 8'd255;

	typedef enum logic [4:0] {
		PS_OPEN_TEST   = 5'b00001,
		PS_CLOSE_NUDGE = 5'b00010,
		PS_CLOSE_TEST  = 5'b00100,
		PS_OPEN_NUDGE  = 5'b01000,
		PS_DONE        = 5'b10000
	} probe_stage_t;

	typedef struct packed {
		logic [THRESH_W-1:0] current_threshold;
		logic [23:0]         movement_timeout;
		logic [15:0]         check_interval;
		logic [23:0]         minimum_run_time;
	} cfg_t;

	typedef struct packed {
		probe_stage_t probe_stage;
		logic [2:0]   status;
		logic [1:0]   position;
		logic [1:0]   operation;
		logic         drive_open;
		logic         drive_close;
		logic [7:0]   stage_timer;
		logic         cached_above;
		logic         cache_valid;
		logic         start_pending;
		logic         open_probe;
		logic         close_probe;
		logic [3:0]   fault;
	} ctrl_t;

endpackage

### rtl/current_sensed_valve_sequencer_top.sv
`timescale 1ns / 1ps
// top level: config registers, sequencer state and the output register
//
// Each accepted item is a 1 ms tick with a current sample or an open, close, stop or
// toggle command, and yields exactly one result showing drives, status, position,
// operation and fault after that item. The block takes one item per clock cycle unless
// an untaken result stalls it: the state update is a single pass of next-state logic,
// and the result appears in the cycle after acceptance from an output register that
// keeps accepting while its result is taken in the same cycle. After reset the block
// starts probing the valve with the open drive on; timers count ticks only and
// saturate. Write configuration only while no result is outstanding.
module current_sensed_valve_sequencer_top #(
	parameter int TIME_BITS = 24
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_wr_en,
	input  logic [1:0]  cfg_index,
	input  logic [23:0] cfg_data,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [15:0] s_tdata,   // current_sample
	input  logic [3:0]  s_tuser,   // mode[2:0], sample_valid
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata    // drive_open, drive_close, valve_status[2:0],
	                               // reported_position[1:0], operation[1:0],
	                               // fault_code[3:0], zero fill
);

	cssv_pkg::cfg_t       cfg_q;
	cssv_pkg::ctrl_t      ctrl_q;
	cssv_pkg::ctrl_t      ctrl_nxt;
	logic [TIME_BITS-1:0] motion_timer_q;
	logic [TIME_BITS-1:0] sample_age_q;
	logic [TIME_BITS-1:0] motion_timer_nxt;
	logic [TIME_BITS-1:0] sample_age_nxt;
	logic                 out_valid_q;
	logic [12:0]          out_data_q;
	logic                 in_accept;

	assign s_tready  = !out_valid_q || m_tready;
	assign in_accept = s_tvalid && s_tready;
	assign m_tvalid  = out_valid_q;
	assign m_tdata   = {3'b000, out_data_q};

	cssv_next #(
		.TIME_BITS(TIME_BITS)
	) u_next (
		.cfg              (cfg_q),
		.mode             (s_tuser[2:0]),
		.current_sample   (s_tdata),
		.sample_valid     (s_tuser[3]),
		.ctrl_cur         (ctrl_q),
		.motion_timer_cur (motion_timer_q),
		.sample_age_cur   (sample_age_q),
		.ctrl_nxt         (ctrl_nxt),
		.motion_timer_nxt (motion_timer_nxt),
		.sample_age_nxt   (sample_age_nxt)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.current_threshold <= 15'd100;
			cfg_q.movement_timeout  <= 24'd30000;
			cfg_q.check_interval    <= 16'd100;
			cfg_q.minimum_run_time  <= 24'd1000;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				cssv_pkg::REG_THRESHOLD: cfg_q.current_threshold <= cfg_data[14:0];
				cssv_pkg::REG_TIMEOUT:   cfg_q.movement_timeout  <= cfg_data;
				cssv_pkg::REG_INTERVAL:  cfg_q.check_interval    <= cfg_data[15:0];
				cssv_pkg::REG_MIN_RUN:   cfg_q.minimum_run_time  <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctrl_q.probe_stage   <= cssv_pkg::PS_OPEN_TEST;
			ctrl_q.status        <= cssv_pkg::ST_UNKNOWN;
			ctrl_q.position      <= cssv_pkg::POS_MID;
			ctrl_q.operation     <= cssv_pkg::OP_IDLE;
			ctrl_q.drive_open    <= 1'b1;
			ctrl_q.drive_close   <= 1'b0;
			ctrl_q.stage_timer   <= 8'd0;
			ctrl_q.cached_above  <= 1'b0;
			ctrl_q.cache_valid   <= 1'b0;
			ctrl_q.start_pending <= 1'b0;
			ctrl_q.open_probe    <= 1'b0;
			ctrl_q.close_probe   <= 1'b0;
			ctrl_q.fault         <= cssv_pkg::FLT_NONE;
			motion_timer_q       <= '0;
			sample_age_q         <= '0;
		end else if (in_accept) begin
			ctrl_q         <= ctrl_nxt;
			motion_timer_q <= motion_timer_nxt;
			sample_age_q   <= sample_age_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (in_accept) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_accept) begin
			out_data_q <= {ctrl_nxt.fault, ctrl_nxt.operation, ctrl_nxt.position,
			               ctrl_nxt.status, ctrl_nxt.drive_close, ctrl_nxt.drive_open};
		end
	end

endmodule

### rtl/cssv_next.sv
`timescale 1ns / 1ps
// next-state logic: applies one tick or command to the sequencer state
module cssv_next #(
	parameter int TIME_BITS = 24
) (
	input  cssv_pkg::cfg_t                 cfg,
	input  logic [2:0]                     mode,
	input  logic signed [cssv_pkg::CURRENT_W-1:0] current_sample,
	input  logic                           sample_valid,
	input  cssv_pkg::ctrl_t                ctrl_cur,
	input  logic [TIME_BITS-1:0]           motion_timer_cur,
	input  logic [TIME_BITS-1:0]           sample_age_cur,
	output cssv_pkg::ctrl_t                ctrl_nxt,
	output logic [TIME_BITS-1:0]           motion_timer_nxt,
	output logic [TIME_BITS-1:0]           sample_age_nxt
);

	localparam int CW = (TIME_BITS > cssv_pkg::CFG_W) ? TIME_BITS : cssv_pkg::CFG_W;

	function automatic cssv_pkg::ctrl_t set_status(cssv_pkg::ctrl_t c, logic [2:0] s);
		cssv_pkg::ctrl_t r;
		r = c;
		if (c.status != s) begin
			r.status = s;
			case (s)
				cssv_pkg::ST_OPEN: begin
					r.position  = cssv_pkg::POS_OPEN;
					r.operation = cssv_pkg::OP_IDLE;
				end
				cssv_pkg::ST_CLOSED: begin
					r.position  = cssv_pkg::POS_CLOSED;
					r.operation = cssv_pkg::OP_IDLE;
				end
				cssv_pkg::ST_OPENING: r.operation = cssv_pkg::OP_OPENING;
				cssv_pkg::ST_CLOSING: r.operation = cssv_pkg::OP_CLOSING;
				default: begin
					r.position  = cssv_pkg::POS_MID;
					r.operation = cssv_pkg::OP_IDLE;
				end
			endcase
		end
		return r;
	endfunction

	function automatic cssv_pkg::ctrl_t do_fault(cssv_pkg::ctrl_t c, logic [3:0] code);
		cssv_pkg::ctrl_t r;
		r = c;
		r.drive_open  = 1'b0;
		r.drive_close = 1'b0;
		r = set_status(r, cssv_pkg::ST_ERROR);
		r.fault = code;
		return r;
	endfunction

	logic [cssv_pkg::CURRENT_W:0] mag;
	logic                         above_now;

	// magnitude in one extra bit so the most negative count stays positive
	assign mag = current_sample[cssv_pkg::CURRENT_W-1]
		? ((cssv_pkg::CURRENT_W+1)'(0) - {current_sample[cssv_pkg::CURRENT_W-1], current_sample})
		: {1'b0, current_sample};
	assign above_now = sample_valid
		&& (mag >= (cssv_pkg::CURRENT_W+1)'(cfg.current_threshold));

	always_comb begin
		cssv_pkg::ctrl_t      c;
		logic [TIME_BITS-1:0] mt;
		logic [TIME_BITS-1:0] sa;
		logic [CW-1:0]        mt_x;
		logic [CW-1:0]        sa_x;
		logic [15:0]          iv;
		logic                 opening;
		logic                 req;
		logic [3:0]           base;

		c       = ctrl_cur;
		mt      = motion_timer_cur;
		sa      = sample_age_cur;
		mt_x    = '0;
		sa_x    = '0;
		iv      = 16'd0;
		opening = 1'b0;
		req     = 1'b0;
		base    = cssv_pkg::FLT_NONE;

		case (mode)
			cssv_pkg::MODE_TICK: begin
				if (c.stage_timer != cssv_pkg::STAGE_MAX) begin
					c.stage_timer = c.stage_timer + 8'd1;
				end
				if (mt != '1) begin
					mt = mt + TIME_BITS'(1);
				end
				if (sa != '1) begin
					sa = sa + TIME_BITS'(1);
				end
				mt_x = CW'(mt);
				sa_x = CW'(sa);

				case (c.probe_stage)
					cssv_pkg::PS_OPEN_TEST: begin
						if (c.stage_timer >= cssv_pkg::PROBE_WAIT) begin
							c.cached_above = above_now;
							c.cache_valid  = 1'b1;
							sa             = '0;
							c.open_probe   = above_now;
							c.drive_open   = 1'b0;
							c.drive_close  = above_now;
							c.stage_timer  = 8'd0;
							c.probe_stage  = above_now ? cssv_pkg::PS_CLOSE_NUDGE
							                           : cssv_pkg::PS_CLOSE_TEST;
						end
					end
					cssv_pkg::PS_CLOSE_NUDGE: begin
						if (c.stage_timer >= cssv_pkg::NUDGE_WAIT) begin
							c.stage_timer = 8'd0;
							c.probe_stage = cssv_pkg::PS_CLOSE_TEST;
						end
					end
					cssv_pkg::PS_CLOSE_TEST, cssv_pkg::PS_OPEN_NUDGE: begin
						if (c.probe_stage == cssv_pkg::PS_CLOSE_TEST
						    && c.stage_timer >= cssv_pkg::PROBE_WAIT) begin
							c.cached_above = above_now;
							c.cache_valid  = 1'b1;
							sa             = '0;
							c.close_probe  = above_now;
							c.drive_open   = above_now;
							c.drive_close  = 1'b0;
							if (above_now) begin
								c.stage_timer = 8'd0;
								c.probe_stage = cssv_pkg::PS_OPEN_NUDGE;
							end else begin
								req = 1'b1;
							end
						end else if (c.probe_stage == cssv_pkg::PS_OPEN_NUDGE
						             && c.stage_timer >= cssv_pkg::NUDGE_WAIT) begin
							c.drive_open  = 1'b0;
							c.drive_close = 1'b0;
							req           = 1'b1;
						end
						// req marks the end of the probe sequence here
						if (req) begin
							c.probe_stage = cssv_pkg::PS_DONE;
							if (c.open_probe == c.close_probe) begin
								c = do_fault(c, c.open_probe ? cssv_pkg::FLT_BOTH_PROBES
								                             : cssv_pkg::FLT_NO_PROBE);
							end else begin
								c.drive_open  = 1'b0;
								c.drive_close = 1'b0;
								c = set_status(c, c.open_probe ? cssv_pkg::ST_CLOSED
								                               : cssv_pkg::ST_OPEN);
							end
						end
					end
					default: begin
						// motion checks
						if (c.status == cssv_pkg::ST_OPENING
						    || c.status == cssv_pkg::ST_CLOSING) begin
							opening = (c.status == cssv_pkg::ST_OPENING);
							base    = opening ? cssv_pkg::FLT_OPEN_NOSTART
							                  : cssv_pkg::FLT_CLOSE_NOSTART;
							req     = 1'b1;
							if (c.start_pending) begin
								if (mt_x < CW'(cfg.check_interval)) begin
									req = 1'b0;
								end else begin
									c.cached_above = above_now;
									c.cache_valid  = 1'b1;
									sa             = '0;
									sa_x           = '0;
									if (!above_now) begin
										c   = do_fault(c, base);
										req = 1'b0;
									end else begin
										c.start_pending = 1'b0;
									end
								end
							end
							if (req) begin
								iv = (cfg.check_interval == 16'd0) ? 16'd1 : cfg.check_interval;
								if (!c.cache_valid || sa_x >= CW'(iv)) begin
									c.cached_above = above_now;
									c.cache_valid  = 1'b1;
									sa             = '0;
								end
								if (!c.cached_above) begin
									if (mt_x < CW'(cfg.minimum_run_time)) begin
										c = do_fault(c, base + cssv_pkg::FLT_EARLY_OFS);
									end else begin
										c.drive_open  = 1'b0;
										c.drive_close = 1'b0;
										c = set_status(c, opening ? cssv_pkg::ST_OPEN
										                          : cssv_pkg::ST_CLOSED);
									end
								end else if (mt_x >= CW'(cfg.movement_timeout)) begin
									c = do_fault(c, base + cssv_pkg::FLT_TIMEOUT_OFS);
								end
							end
						end
					end
				endcase
			end
			cssv_pkg::MODE_OPEN, cssv_pkg::MODE_CLOSE, cssv_pkg::MODE_TOGGLE: begin
				if (mode == cssv_pkg::MODE_OPEN) begin
					opening = 1'b1;
				end else if (mode == cssv_pkg::MODE_CLOSE) begin
					opening = 1'b0;
				end else begin
					opening = (c.position != cssv_pkg::POS_OPEN);
				end
				// open while open or close while closed is ignored
				if (c.status != (opening ? cssv_pkg::ST_OPEN : cssv_pkg::ST_CLOSED)) begin
					c.probe_stage   = cssv_pkg::PS_DONE;
					mt              = '0;
					c.start_pending = 1'b1;
					c.cache_valid   = 1'b0;
					c.fault         = cssv_pkg::FLT_NONE;
					c.drive_open    = opening;
					c.drive_close   = !opening;
					c = set_status(c, opening ? cssv_pkg::ST_OPENING : cssv_pkg::ST_CLOSING);
				end
			end
			cssv_pkg::MODE_STOP: begin
				c.drive_open  = 1'b0;
				c.drive_close = 1'b0;
				c.operation   = cssv_pkg::OP_IDLE;
			end
			default: begin
			end
		endcase

		ctrl_nxt         = c;
		motion_timer_nxt = mt;
		sample_age_nxt   = sa;
	end

endmodule
